// ===== sv/hslrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Types and constants shared by the HSL to RGB color wheel pipeline.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

  localparam int HUE_W   = 9;
  localparam int CHAN_W  = 8;
  localparam int SECT_W  = 3;
  localparam int OFS_W   = 6;

  localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hff;
  localparam logic [CHAN_W-1:0] LIGHT_MID = 8'h80;

  // Hue sector start angles, 60 degrees apart.
  localparam logic [HUE_W-1:0] HUE_60  = 9'd60;
  localparam logic [HUE_W-1:0] HUE_120 = 9'd120;
  localparam logic [HUE_W-1:0] HUE_180 = 9'd180;
  localparam logic [HUE_W-1:0] HUE_240 = 9'd240;
  localparam logic [HUE_W-1:0] HUE_300 = 9'd300;
  localparam logic [HUE_W-1:0] HUE_360 = 9'd360;

  // Sector codes.
  localparam logic [SECT_W-1:0] SECT_RY = 3'd0;  // red full, green rising
  localparam logic [SECT_W-1:0] SECT_YG = 3'd1;  // green full, red falling
  localparam logic [SECT_W-1:0] SECT_GC = 3'd2;  // green full, blue rising
  localparam logic [SECT_W-1:0] SECT_CB = 3'd3;  // blue full, green falling
  localparam logic [SECT_W-1:0] SECT_BM = 3'd4;  // blue full, red rising
  localparam logic [SECT_W-1:0] SECT_MR = 3'd5;  // red full, blue falling

  // First stage: hue decoded, base chroma from lightness.
  typedef struct packed {
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] base;
    logic [CHAN_W-1:0] ramp;
    logic [SECT_W-1:0] sector;
    logic              blank;
  } hslrgb_s1_t;

  // Second stage: chroma scaled by saturation.
  typedef struct packed {
    logic [CHAN_W-1:0] chroma;
    logic [CHAN_W-1:0] ramp;
    logic [SECT_W-1:0] sector;
    logic              blank;
  } hslrgb_s2_t;

  // Final stage: color channels.
  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } hslrgb_rgb_t;

endpackage

// ===== sv/hsl_to_rgb_color_wheel_unit.sv =====
// ----------------------------------------------------------------------------
// hsl_to_rgb_color_wheel_unit
// Three-stage pipelined HSL to RGB color wheel converter on stream ports.
// ----------------------------------------------------------------------------
// Converts a hue in degrees plus 8-bit saturation and lightness into 8-bit
// red, green and blue. One item is accepted every cycle while the output side
// takes results; each item passes through three registered stages (hue
// decode and base chroma, saturation multiply, ramp multiply and channel
// select), and its result is offered on m_tvalid from the last of them. The
// rate is set by the stage handshake: a stage moves on when the stage after it
// is empty or moving, so a stall on m_tready fills the bubbles and then holds
// s_tready low without dropping or repeating an item. Hues of 360 and above
// give black. Reset clears only the stage valid flags.
module hsl_to_rgb_color_wheel_unit
  import hslrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // hue[8:0], sat[16:9], light[24:17], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

  // Input field split.
  logic [HUE_W-1:0]  hue;
  logic [CHAN_W-1:0] sat;
  logic [CHAN_W-1:0] light;

  assign hue   = s_tdata[8:0];
  assign sat   = s_tdata[16:9];
  assign light = s_tdata[24:17];

  // Stage valid flags and advance conditions.
  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  assign adv3     = !v3 || m_tready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign s_tready = adv1;

  // --------------------------------------------------------------------------
  // Stage 1: find the hue sector by compare chain, turn the sector offset
  // into a 0..250 ramp (offset * 17 / 4), and form the base chroma.
  // --------------------------------------------------------------------------
  hslrgb_s1_t        s1_next, s1;
  logic [HUE_W-1:0]  sect_start;
  logic [HUE_W-1:0]  ofs_full;
  logic [OFS_W-1:0]  ofs;
  logic [OFS_W+4:0]  ofs_x17;

  always_comb begin
    if (hue < HUE_60) begin
      s1_next.sector = SECT_RY;
      sect_start     = '0;
    end else if (hue < HUE_120) begin
      s1_next.sector = SECT_YG;
      sect_start     = HUE_60;
    end else if (hue < HUE_180) begin
      s1_next.sector = SECT_GC;
      sect_start     = HUE_120;
    end else if (hue < HUE_240) begin
      s1_next.sector = SECT_CB;
      sect_start     = HUE_180;
    end else if (hue < HUE_300) begin
      s1_next.sector = SECT_BM;
      sect_start     = HUE_240;
    end else begin
      s1_next.sector = SECT_MR;
      sect_start     = HUE_300;
    end
    ofs_full = hue - sect_start;
    ofs      = ofs_full[OFS_W-1:0];
    ofs_x17  = {1'b0, ofs, 4'b0000} + {5'b00000, ofs};
    s1_next.ramp  = ofs_x17[CHAN_W+1:2];
    s1_next.blank = (hue >= HUE_360);
    s1_next.sat   = sat;
    // Chroma rises as twice the lightness, peaks at the midpoint, then
    // falls as the inverse of twice the excess.
    if (light == LIGHT_MID) begin
      s1_next.base = CHAN_FULL;
    end else if (light > LIGHT_MID) begin
      s1_next.base = ~{light[CHAN_W-2:0], 1'b0};
    end else begin
      s1_next.base = {light[CHAN_W-2:0], 1'b0};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale chroma by saturation. A full base chroma is replaced by
  // the saturation itself; a full saturation leaves chroma untouched.
  // --------------------------------------------------------------------------
  hslrgb_s2_t          s2_next, s2;
  logic [2*CHAN_W-1:0] sat_prod;

  always_comb begin
    sat_prod = {{CHAN_W{1'b0}}, s1.base} * {{CHAN_W{1'b0}}, s1.sat};
    if (s1.base == CHAN_FULL) begin
      s2_next.chroma = s1.sat;
    end else if (s1.sat != CHAN_FULL) begin
      s2_next.chroma = sat_prod[2*CHAN_W-1:CHAN_W];
    end else begin
      s2_next.chroma = s1.base;
    end
    s2_next.ramp   = s1.ramp;
    s2_next.sector = s1.sector;
    s2_next.blank  = s1.blank;
  end

  // --------------------------------------------------------------------------
  // Stage 3: rising and falling ramps scaled by chroma, then route chroma
  // and ramps to the channels of the sector.
  // --------------------------------------------------------------------------
  hslrgb_rgb_t         rgb_next, rgb;
  logic [CHAN_W-1:0]   ramp_dn;
  logic [2*CHAN_W-1:0] up_prod;
  logic [2*CHAN_W-1:0] dn_prod;
  logic [CHAN_W-1:0]   up;
  logic [CHAN_W-1:0]   dn;

  always_comb begin
    ramp_dn = CHAN_FULL - s2.ramp;
    up_prod = {{CHAN_W{1'b0}}, s2.chroma} * {{CHAN_W{1'b0}}, s2.ramp};
    dn_prod = {{CHAN_W{1'b0}}, s2.chroma} * {{CHAN_W{1'b0}}, ramp_dn};
    if (s2.chroma == CHAN_FULL) begin
      up = s2.ramp;
      dn = ramp_dn;
    end else begin
      up = up_prod[2*CHAN_W-1:CHAN_W];
      dn = dn_prod[2*CHAN_W-1:CHAN_W];
    end
    rgb_next = '0;
    if (!s2.blank) begin
      case (s2.sector)
        SECT_RY: begin
          rgb_next.red   = s2.chroma;
          rgb_next.green = up;
        end
        SECT_YG: begin
          rgb_next.red   = dn;
          rgb_next.green = s2.chroma;
        end
        SECT_GC: begin
          rgb_next.green = s2.chroma;
          rgb_next.blue  = up;
        end
        SECT_CB: begin
          rgb_next.green = dn;
          rgb_next.blue  = s2.chroma;
        end
        SECT_BM: begin
          rgb_next.red  = up;
          rgb_next.blue = s2.chroma;
        end
        default: begin
          rgb_next.red  = s2.chroma;
          rgb_next.blue = dn;
        end
      endcase
    end
  end

  // Valid flags: load on advance, drop when the stage empties downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Payload: advance with the stage, hold while stalled.
  always_ff @(posedge clk) begin
    if (adv1) s1  <= s1_next;
    if (adv2) s2  <= s2_next;
    if (adv3) rgb <= rgb_next;
  end

  assign m_tvalid = v3;
  assign m_tdata  = rgb;

endmodule
